### hw/rtl/actuator_safety_output_controller_macros.svh
// ----------------------------------------------------------------------------
// Actuator safety output controller assertion macros
// Shared property forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_SAFETY_OUTPUT_CONTROLLER_MACROS_SVH
`define ACTUATOR_SAFETY_OUTPUT_CONTROLLER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASOC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/asoc_pkg.sv
// ----------------------------------------------------------------------------
// asoc_pkg
// Types, codes and constants of the actuator safety output controller.
// ----------------------------------------------------------------------------
`default_nettype none

package asoc_pkg;

  // Sizes
  localparam int CHANNELS_DEF = 8;
  localparam int SLOTS        = 8;   // mask width, slots addressable by a request
  localparam int SLOT_W       = 3;
  localparam int DUTY_W       = 7;
  localparam int AGE_W        = 32;
  localparam int CAGE_W       = 16;
  localparam int SIL_W        = 16;
  localparam int ON_LIMIT_W   = 26;  // 65535 s in ms
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  // Constants
  localparam logic [DUTY_W-1:0] DUTY_FULL       = 7'd100;
  localparam int                MS_PER_S        = 1000;
  localparam logic [15:0]       TIMEOUT_RESET   = 16'd5000;
  localparam logic [15:0]       DELAY_RESET     = 16'd3000;

  // Action codes
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_COMMAND = 3'd1,
    ACT_MANUAL  = 3'd2,
    ACT_ESTOP   = 3'd3,
    ACT_LINK    = 3'd4
  } action_t;

  // Network command codes
  typedef enum logic [1:0] {
    CMD_OFF     = 2'd0,
    CMD_ON      = 2'd1,
    CMD_PWM     = 2'd2,
    CMD_UNKNOWN = 2'd3
  } command_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOSLOT = 2'd1,
    ST_BADCMD = 2'd2,
    ST_FAST   = 2'd3
  } status_t;

  // Register indexes
  typedef enum logic [2:0] {
    REG_ENABLE_MASK = 3'd0,
    REG_PWM_MASK    = 3'd1,
    REG_MAX_ON      = 3'd2,
    REG_MIN_CYCLE   = 3'd3,
    REG_TIMEOUT     = 3'd4,
    REG_DELAY       = 3'd5
  } reg_index_t;

  // Request payload
  typedef struct packed {
    logic [2:0] action;
    logic [2:0] slot;
    logic [1:0] command;
    logic [7:0] duty;
    logic       manual_on;
    logic       link_up;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]        status;
    logic              channel_on;
    logic [DUTY_W-1:0] drive_duty;
    logic              manual_flag;
    logic              degraded;
    logic              shutoff_event;
  } rsp_t;

  // Configuration seen by the channel logic
  typedef struct packed {
    logic [SLOTS-1:0]      enable_mask;
    logic [SLOTS-1:0]      pwm_mask;
    logic                  on_limit_en;
    logic [ON_LIMIT_W-1:0] on_limit;
    logic [15:0]           min_cycle;
    logic [15:0]           timeout;
    logic [15:0]           delay;
  } cfg_t;

  // Duty clamp to full scale
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [7:0] d);
    return (d > 8'(DUTY_FULL)) ? DUTY_FULL : d[DUTY_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/asoc_regs.sv
// ----------------------------------------------------------------------------
// asoc_regs
// APB configuration registers; also keeps the max on-time in milliseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module asoc_regs import asoc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic [SLOTS-1:0]      enable_mask;
  logic [SLOTS-1:0]      pwm_mask;
  logic [15:0]           max_on_seconds;
  logic [ON_LIMIT_W-1:0] on_limit;
  logic [15:0]           min_cycle_ms;
  logic [15:0]           cmd_timeout;
  logic [15:0]           degraded_delay_ms;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask       <= '0;
      pwm_mask          <= '0;
      max_on_seconds    <= '0;
      on_limit          <= '0;
      min_cycle_ms      <= '0;
      cmd_timeout       <= TIMEOUT_RESET;
      degraded_delay_ms <= DELAY_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE_MASK: enable_mask <= pwdata[SLOTS-1:0];
        REG_PWM_MASK:    pwm_mask    <= pwdata[SLOTS-1:0];
        REG_MAX_ON: begin
          max_on_seconds <= pwdata[15:0];
          on_limit       <= ON_LIMIT_W'({10'b0, pwdata[15:0]} * ON_LIMIT_W'(MS_PER_S));
        end
        REG_MIN_CYCLE:   min_cycle_ms      <= pwdata[15:0];
        REG_TIMEOUT:     cmd_timeout       <= pwdata[15:0];
        REG_DELAY:       degraded_delay_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_ENABLE_MASK: prdata = {24'b0, enable_mask};
      REG_PWM_MASK:    prdata = {24'b0, pwm_mask};
      REG_MAX_ON:      prdata = {16'b0, max_on_seconds};
      REG_MIN_CYCLE:   prdata = {16'b0, min_cycle_ms};
      REG_TIMEOUT:     prdata = {16'b0, cmd_timeout};
      REG_DELAY:       prdata = {16'b0, degraded_delay_ms};
      default:         prdata = '0;
    endcase
  end

  assign cfg.enable_mask = enable_mask;
  assign cfg.pwm_mask    = pwm_mask;
  assign cfg.on_limit_en = |max_on_seconds;
  assign cfg.on_limit    = on_limit;
  assign cfg.min_cycle   = min_cycle_ms;
  assign cfg.timeout     = cmd_timeout;
  assign cfg.delay       = degraded_delay_ms;

endmodule

`default_nettype wire

### hw/rtl/asoc_core.sv
// ----------------------------------------------------------------------------
// asoc_core
// Per-channel state and the single-pass update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module asoc_core import asoc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  req_t req,
  input  logic step,
  output rsp_t rsp
);

  // Channel state
  logic              on_flags          [CHANNELS];
  logic              on_flags_next     [CHANNELS];
  logic [DUTY_W-1:0] duty_store        [CHANNELS];
  logic [DUTY_W-1:0] duty_store_next   [CHANNELS];
  logic              manual_flags      [CHANNELS];
  logic              manual_flags_next [CHANNELS];
  logic [AGE_W-1:0]  change_age        [CHANNELS];
  logic [AGE_W-1:0]  change_age_next   [CHANNELS];
  logic              command_seen      [CHANNELS];
  logic              command_seen_next [CHANNELS];
  logic [CAGE_W-1:0] command_age       [CHANNELS];
  logic [CAGE_W-1:0] command_age_next  [CHANNELS];
  logic              link_state, link_state_next;
  logic              degraded_flag, degraded_flag_next;
  logic [SIL_W-1:0]  silence_ticks, silence_ticks_next;

  logic [AGE_W-1:0]  age_inc  [CHANNELS];
  logic [CAGE_W-1:0] cage_inc [CHANNELS];
  logic [CHANNELS-1:0] present, hit, recent;
  logic              slot_present;
  logic [AGE_W-1:0]  sel_age;
  logic              cmd_known, new_on, lockout;
  logic [DUTY_W-1:0] new_duty;
  logic [1:0]        status;
  logic              shut;
  logic              rd_on, rd_man;
  logic [DUTY_W-1:0] rd_duty;

  // Which channels exist, and which one the request addresses
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    if (g < SLOTS) begin : g_slot
      assign present[g] = cfg.enable_mask[g];
    end else begin : g_noslot
      assign present[g] = 1'b0;
    end
    assign hit[g] = (32'(req.slot) == g);
  end

  assign slot_present = (32'(req.slot) < CHANNELS) && cfg.enable_mask[req.slot];

  // Saturating age increments and recent-command flags
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      age_inc[i]  = (change_age[i] == '1) ? change_age[i] : change_age[i] + 1'b1;
      cage_inc[i] = (command_age[i] == '1) ? command_age[i] : command_age[i] + 1'b1;
      recent[i]   = present[i] && command_seen[i] && (cage_inc[i] < cfg.timeout);
    end
  end

  // Change age of the addressed channel, for the lockout
  always_comb begin
    sel_age = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (hit[i]) sel_age = change_age[i];
    end
  end

  // Command decode
  always_comb begin
    cmd_known = 1'b1;
    new_on    = 1'b0;
    new_duty  = '0;
    case (req.command)
      CMD_OFF: begin
        new_on   = 1'b0;
        new_duty = '0;
      end
      CMD_ON: begin
        new_on   = 1'b1;
        new_duty = DUTY_FULL;
      end
      CMD_PWM: begin
        new_on   = 1'b1;
        new_duty = clamp_duty(req.duty);
      end
      default: cmd_known = 1'b0;
    endcase
  end

  assign lockout = (cfg.min_cycle != '0) && (sel_age < {16'b0, cfg.min_cycle});

  // Next state
  always_comb begin
    on_flags_next      = on_flags;
    duty_store_next    = duty_store;
    manual_flags_next  = manual_flags;
    change_age_next    = change_age;
    command_seen_next  = command_seen;
    command_age_next   = command_age;
    link_state_next    = link_state;
    degraded_flag_next = degraded_flag;
    silence_ticks_next = silence_ticks;
    status             = ST_OK;
    shut               = 1'b0;

    case (req.action)
      ACT_TICK: begin
        change_age_next  = age_inc;
        command_age_next = cage_inc;
        // silence tracking
        if (link_state && (|present) && !(|recent)) begin
          silence_ticks_next = (silence_ticks == '1) ? silence_ticks
                                                     : silence_ticks + 1'b1;
          if (silence_ticks_next > cfg.delay) degraded_flag_next = 1'b1;
        end else begin
          silence_ticks_next = '0;
        end
        // max on-time shutoff
        if (cfg.on_limit_en) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (present[i] && on_flags[i] && age_inc[i] >= {6'b0, cfg.on_limit}) begin
              on_flags_next[i]   = 1'b0;
              change_age_next[i] = '0;
              shut               = 1'b1;
            end
          end
        end
      end
      ACT_COMMAND: begin
        if (!slot_present) begin
          status = ST_NOSLOT;
        end else if (!cmd_known) begin
          status = ST_BADCMD;
        end else if (lockout) begin
          status = ST_FAST;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (hit[i]) begin
              command_seen_next[i] = 1'b1;
              command_age_next[i]  = '0;
              if (on_flags[i] != new_on || duty_store[i] != new_duty) begin
                on_flags_next[i]     = new_on;
                duty_store_next[i]   = new_duty;
                manual_flags_next[i] = 1'b0;
                change_age_next[i]   = '0;
              end
            end
          end
          degraded_flag_next = 1'b0;
          silence_ticks_next = '0;
        end
      end
      ACT_MANUAL: begin
        if (!slot_present) begin
          status = ST_NOSLOT;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (hit[i]) begin
              on_flags_next[i]     = req.manual_on;
              duty_store_next[i]   = clamp_duty(req.duty);
              manual_flags_next[i] = 1'b1;
              change_age_next[i]   = '0;
            end
          end
        end
      end
      ACT_ESTOP: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (present[i]) begin
            on_flags_next[i]   = 1'b0;
            duty_store_next[i] = '0;
            change_age_next[i] = '0;
          end
        end
      end
      ACT_LINK: begin
        link_state_next    = req.link_up;
        degraded_flag_next = !req.link_up;
        silence_ticks_next = '0;
      end
      default: ;
    endcase
  end

  // Addressed channel after the update
  always_comb begin
    rd_on   = 1'b0;
    rd_man  = 1'b0;
    rd_duty = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (hit[i] && present[i]) begin
        rd_on   = on_flags_next[i];
        rd_man  = manual_flags_next[i];
        rd_duty = duty_store_next[i];
      end
    end
  end

  // Result
  always_comb begin
    rsp.status      = status;
    rsp.channel_on  = rd_on;
    rsp.manual_flag = rd_man;
    if (!rd_on) begin
      rsp.drive_duty = '0;
    end else if (cfg.pwm_mask[req.slot] && rd_duty < DUTY_FULL) begin
      rsp.drive_duty = rd_duty;
    end else begin
      rsp.drive_duty = DUTY_FULL;
    end
    rsp.degraded      = degraded_flag_next;
    rsp.shutoff_event = shut;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        on_flags[i]     <= 1'b0;
        duty_store[i]   <= '0;
        manual_flags[i] <= 1'b0;
        change_age[i]   <= '1;
        command_seen[i] <= 1'b0;
        command_age[i]  <= '0;
      end
      link_state    <= 1'b0;
      degraded_flag <= 1'b0;
      silence_ticks <= '0;
    end else if (step) begin
      on_flags      <= on_flags_next;
      duty_store    <= duty_store_next;
      manual_flags  <= manual_flags_next;
      change_age    <= change_age_next;
      command_seen  <= command_seen_next;
      command_age   <= command_age_next;
      link_state    <= link_state_next;
      degraded_flag <= degraded_flag_next;
      silence_ticks <= silence_ticks_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/actuator_safety_output_controller.sv
// ----------------------------------------------------------------------------
// actuator_safety_output_controller
// Multi-channel actuator output controller with lockout, max on-time,
// emergency stop and degraded-mode tracking.
//
//   channel  direction  handshake                       payload
//   req      in         req_valid / req_ready           req_t
//   rsp      out        rsp_valid / rsp_ready           rsp_t
//   apb      in/out     psel & penable & pwrite/pready  paddr, pwdata, prdata
//
// One request per cycle sustained while responses are taken; a taken request
// loads the input register, then the response register (input, then response).
// The per-channel update is one pass of logic between those two registers.
// Reset is synchronous; no clearing pass is needed after it.
// A stalled response holds the response register; the input register still
// takes a request if the response drains in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module actuator_safety_output_controller import asoc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  req_t req_hold;
  logic req_full;
  logic advance;
  rsp_t core_rsp;

  assign pready = 1'b1;

  asoc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Pipeline control
  assign advance   = req_full && (!rsp_valid || rsp_ready);
  assign req_ready = !req_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) req_full <= req_valid;
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_hold <= req;
    if (advance) rsp <= core_rsp;
  end

  asoc_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (req_hold),
    .step (advance),
    .rsp  (core_rsp)
  );

endmodule

`default_nettype wire

### hw/rtl/asoc_checker.sv
// ----------------------------------------------------------------------------
// asoc_checker
// Port-level checks on responses of the output controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "actuator_safety_output_controller_macros.svh"

module asoc_checker import asoc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // Drive never above full scale, and zero when the channel is off
  `ASOC_ASSERT_SAME(a_drive_off, clk, rst, rsp_valid && !rsp.channel_on, rsp.drive_duty == '0, "drive on an off channel")
  `ASOC_ASSERT_SAME(a_drive_max, clk, rst, rsp_valid, rsp.drive_duty <= DUTY_FULL, "drive above full scale")

  // A missing slot reports nothing of a channel
  `ASOC_ASSERT_SAME(a_noslot, clk, rst, rsp_valid && rsp.status == ST_NOSLOT, !rsp.channel_on && !rsp.manual_flag, "missing slot reports channel state")

  // Shutoff comes only from a tick, which always reports ok
  `ASOC_ASSERT_SAME(a_shut_ok, clk, rst, rsp_valid && rsp.status != ST_OK, !rsp.shutoff_event, "shutoff on a failed request")

  // A stalled response holds
  `ASOC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind actuator_safety_output_controller asoc_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
